// ----- sv/i2cwr_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cwr_pkg
// Shared types and constants for the I2C write/read sequencer core.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cwr_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int PTR_W     = 5;
  localparam int CNT_W     = 5;
  localparam int ADDR_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 7;
  localparam logic [PTR_W-1:0] PTR_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_EVENT = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_START     = 3'd0,
    ST_RESTART   = 3'd1,
    ST_ADDR_W_OK = 3'd2,
    ST_DATA_OK   = 3'd3,
    ST_RX_ACK    = 3'd4,
    ST_ADDR_R_OK = 3'd5,
    ST_RX_NACK   = 3'd6,
    ST_ERROR     = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_NACK    = 3'd2,
    CMD_ACK     = 3'd3,
    CMD_RESTART = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_RELEASE = 3'd6
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDR  = 2'd0,
    CFG_WRITE_COUNT = 2'd1,
    CFG_READ_COUNT  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       tx_from_mem;
    logic       rd_from_mem;
    logic       busy;
  } s1_t;

endpackage

`default_nettype wire

// ----- sv/i2c_master_write_read_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// i2c_master_write_read_sequencer_core
// Sequences one combined I2C write/read transaction around a byte buffer.
// Input channel (in_valid/in_stall) carries one item per operation: load a
// buffer byte, begin a transaction, report a bus status event, or read a
// buffer byte. Each accepted item gives exactly one result item on the
// output channel (out_valid/out_stall): a bus command, a transmit byte with
// its valid flag, the buffer byte read back and the busy flag.
// The buffer is a 16-entry synchronous RAM. Control state (pointer, busy)
// updates at acceptance, the RAM is written at acceptance and read in the
// same edge; the read data joins the item one stage later.
// An item is held in the stage-1 register, then in the result register that
// drives out_valid. Throughput: one item per cycle unless stalled, set by the
// single RAM access each item needs. The result register and the read stage
// part the channels, so a new item is taken while a finished result waits;
// in_stall rises only when both are full and out_stall is high.
// Reset (rst_n low, synchronous) clears busy, pointer, configuration and the
// pipeline valid flags; buffer contents stay undefined until loaded. The user
// sets configuration via cfg_we/cfg_index/cfg_data only while idle; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_write_read_sequencer_core
  import i2cwr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_operation,
  input  wire logic [3:0]           in_buffer_index,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic [2:0]           in_bus_status,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                out_bus_command,
  output logic [7:0]                out_transmit_byte,
  output logic                      out_transmit_valid,
  output logic [7:0]                out_buffer_byte,
  output logic                      out_busy_res
);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] mem_q_r;

  logic [ADDR_W-1:0] slave_addr_r;
  logic [CNT_W-1:0]  write_count_r;
  logic [CNT_W-1:0]  read_count_r;

  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             busy_r, busy_nxt;

  logic s1_valid_r, s1_valid_nxt;
  s1_t  s1_r, s1_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [2:0] out_cmd_r;
  logic [7:0] out_tx_r;
  logic       out_txv_r;
  logic [7:0] out_rd_r;
  logic       out_busy_r;

  logic              s1_adv;
  logic              in_accept;
  logic              mem_we;
  logic [BUF_AW-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic              mem_re;
  logic [BUF_AW-1:0] mem_ra;

  logic [7:0]       addr_byte;
  logic             idx_ok;
  logic             ptr_ok;
  logic [PTR_W-1:0] ptr_inc;
  logic [PTR_W:0]   ptr_plus1;
  op_t              op;
  status_t          status;

  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign op        = op_t'(in_operation);
  assign status    = status_t'(in_bus_status);
  assign addr_byte = {slave_addr_r, 1'b0};
  assign idx_ok    = 32'(in_buffer_index) < BUF_DEPTH;
  assign ptr_ok    = 32'(ptr_r) < BUF_DEPTH;
  assign ptr_inc   = (ptr_r == PTR_MAX) ? ptr_r : ptr_r + PTR_W'(1);

  always_comb begin
    ptr_nxt   = ptr_r;
    busy_nxt  = busy_r;
    mem_we    = 1'b0;
    mem_wa    = BUF_AW'(in_buffer_index);
    mem_wd    = in_data_byte;
    mem_re    = 1'b0;
    mem_ra    = BUF_AW'(in_buffer_index);
    ptr_plus1 = {1'b0, ptr_r} + (PTR_W+1)'(1);
    s1_nxt    = '{cmd: CMD_NONE, tx_byte: 8'd0, tx_valid: 1'b0,
                  tx_from_mem: 1'b0, rd_from_mem: 1'b0, busy: busy_r};
    case (op)
      OP_LOAD: begin
        mem_we = idx_ok;
      end
      OP_BEGIN: begin
        if (!busy_r) begin
          busy_nxt   = 1'b1;
          s1_nxt.cmd = CMD_START;
        end
      end
      OP_READ: begin
        mem_re             = idx_ok;
        s1_nxt.rd_from_mem = idx_ok;
      end
      OP_EVENT: begin
        if (busy_r) begin
          case (status)
            ST_START: begin
              s1_nxt.tx_byte  = addr_byte | {7'd0, (write_count_r == '0)};
              s1_nxt.tx_valid = 1'b1;
              s1_nxt.cmd      = CMD_NACK;
              ptr_nxt         = '0;
            end
            ST_RESTART: begin
              s1_nxt.tx_byte  = addr_byte | 8'd1;
              s1_nxt.tx_valid = 1'b1;
              s1_nxt.cmd      = CMD_NACK;
              ptr_nxt         = '0;
            end
            ST_ADDR_W_OK, ST_DATA_OK: begin
              if (ptr_r < write_count_r) begin
                mem_re             = ptr_ok;
                mem_ra             = BUF_AW'(ptr_r);
                s1_nxt.tx_from_mem = ptr_ok;
                s1_nxt.tx_valid    = 1'b1;
                s1_nxt.cmd         = CMD_NACK;
                ptr_nxt            = ptr_inc;
              end else if (read_count_r != '0) begin
                s1_nxt.cmd = CMD_RESTART;
              end else begin
                s1_nxt.cmd = CMD_STOP;
                busy_nxt   = 1'b0;
              end
            end
            ST_RX_ACK, ST_ADDR_R_OK: begin
              if (status == ST_RX_ACK) begin
                mem_we    = ptr_ok;
                mem_wa    = BUF_AW'(ptr_r);
                ptr_nxt   = ptr_inc;
                ptr_plus1 = {1'b0, ptr_inc} + (PTR_W+1)'(1);
              end
              s1_nxt.cmd = (ptr_plus1 < {1'b0, read_count_r}) ? CMD_ACK : CMD_NACK;
            end
            ST_RX_NACK: begin
              mem_we     = ptr_ok;
              mem_wa     = BUF_AW'(ptr_r);
              s1_nxt.cmd = CMD_STOP;
              busy_nxt   = 1'b0;
            end
            default: begin
              s1_nxt.cmd = CMD_RELEASE;
              busy_nxt   = 1'b0;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    s1_nxt.busy = busy_nxt;
  end

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (in_accept && mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_accept && mem_re) begin
      mem_q_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r  <= '0;
      write_count_r <= '0;
      read_count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SLAVE_ADDR:  slave_addr_r  <= cfg_data[ADDR_W-1:0];
        CFG_WRITE_COUNT: write_count_r <= cfg_data[CNT_W-1:0];
        CFG_READ_COUNT:  read_count_r  <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      busy_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        ptr_r  <= ptr_nxt;
        busy_r <= busy_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_cmd_r  <= s1_r.cmd;
      out_tx_r   <= s1_r.tx_from_mem ? mem_q_r : s1_r.tx_byte;
      out_txv_r  <= s1_r.tx_valid;
      out_rd_r   <= s1_r.rd_from_mem ? mem_q_r : 8'd0;
      out_busy_r <= s1_r.busy;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bus_command    = out_cmd_r;
  assign out_transmit_byte  = out_tx_r;
  assign out_transmit_valid = out_txv_r;
  assign out_buffer_byte    = out_rd_r;
  assign out_busy_res       = out_busy_r;

endmodule

`default_nettype wire

// ----- tb/i2c_master_write_read_sequencer_core_checker.sv -----
// ----------------------------------------------------------------------------
// i2c_master_write_read_sequencer_core_checker
// Watches the configuration port and both item channels of the sequencer,
// keeps its own copy of the buffer, pointer, busy flag and registers, works
// out the result of every accepted input item and compares each accepted
// result item, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module i2c_master_write_read_sequencer_core_checker
  import i2cwr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           in_operation,
  input  logic [3:0]           in_buffer_index,
  input  logic [7:0]           in_data_byte,
  input  logic [2:0]           in_bus_status,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [2:0]           out_bus_command,
  input  logic [7:0]           out_transmit_byte,
  input  logic                 out_transmit_valid,
  input  logic [7:0]           out_buffer_byte,
  input  logic                 out_busy_res,
  output int                   errors,
  output int                   pending,
  output int                   checked
);

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] rd_data;
    logic       busy;
  } bus_result_t;

  logic [7:0]       msg_buf [BUF_DEPTH];
  logic [PTR_W-1:0] buf_ptr;
  logic             xfer_busy;
  logic [ADDR_W-1:0] slave_addr;
  logic [CNT_W-1:0] write_cnt;
  logic [CNT_W-1:0] read_cnt;

  bus_result_t awaited_results [$];

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic bus_result_t sequencer_step(op_t op, logic [3:0] idx,
                                                 logic [7:0] data, status_t st);
    bus_result_t r;
    logic [7:0]  addr_byte;
    r = '{cmd: CMD_NONE, tx_byte: 8'h00, tx_valid: 1'b0, rd_data: 8'h00, busy: 1'b0};
    addr_byte = {slave_addr, 1'b0};
    case (op)
      OP_LOAD: msg_buf[idx] = data;
      OP_BEGIN: begin
        if (!xfer_busy) begin
          xfer_busy = 1'b1;
          r.cmd = CMD_START;
        end
      end
      OP_READ: r.rd_data = msg_buf[idx];
      default: begin
        if (xfer_busy) begin
          case (st)
            ST_START, ST_RESTART: begin
              r.tx_byte  = addr_byte | ((st == ST_RESTART || write_cnt == 0) ? 8'h01 : 8'h00);
              r.tx_valid = 1'b1;
              r.cmd      = CMD_NACK;
              buf_ptr    = '0;
            end
            ST_ADDR_W_OK, ST_DATA_OK: begin
              if (buf_ptr < write_cnt) begin
                r.tx_byte  = (buf_ptr < BUF_DEPTH) ? msg_buf[buf_ptr[BUF_AW-1:0]] : 8'h00;
                r.tx_valid = 1'b1;
                r.cmd      = CMD_NACK;
                if (buf_ptr != PTR_MAX) buf_ptr++;
              end else if (read_cnt != 0) begin
                r.cmd = CMD_RESTART;
              end else begin
                r.cmd     = CMD_STOP;
                xfer_busy = 1'b0;
              end
            end
            ST_RX_ACK, ST_ADDR_R_OK: begin
              if (st == ST_RX_ACK) begin
                if (buf_ptr < BUF_DEPTH) msg_buf[buf_ptr[BUF_AW-1:0]] = data;
                if (buf_ptr != PTR_MAX) buf_ptr++;
              end
              r.cmd = (int'(buf_ptr) + 1 < int'(read_cnt)) ? CMD_ACK : CMD_NACK;
            end
            ST_RX_NACK: begin
              if (buf_ptr < BUF_DEPTH) msg_buf[buf_ptr[BUF_AW-1:0]] = data;
              r.cmd     = CMD_STOP;
              xfer_busy = 1'b0;
            end
            default: begin
              r.cmd     = CMD_RELEASE;
              xfer_busy = 1'b0;
            end
          endcase
        end
      end
    endcase
    r.busy = xfer_busy;
    return r;
  endfunction

  always @(posedge clk) begin
    bus_result_t want;
    if (!rst_n) begin
      buf_ptr    = '0;
      xfer_busy  = 1'b0;
      slave_addr = '0;
      write_cnt  = '0;
      read_cnt   = '0;
      for (int i = 0; i < BUF_DEPTH; i++) msg_buf[i] = 8'h00;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SLAVE_ADDR:  slave_addr = cfg_data[ADDR_W-1:0];
          CFG_WRITE_COUNT: write_cnt  = cfg_data[CNT_W-1:0];
          CFG_READ_COUNT:  read_cnt   = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no item outstanding, bus_command",
                          {5'd0, out_bus_command}, 8'h00);
        end else begin
          want = awaited_results.pop_front();
          if (out_bus_command !== want.cmd)
            report_mismatch("bus_command", {5'd0, out_bus_command}, {5'd0, want.cmd});
          if (out_transmit_byte !== want.tx_byte)
            report_mismatch("transmit_byte", out_transmit_byte, want.tx_byte);
          if (out_transmit_valid !== want.tx_valid)
            report_mismatch("transmit_valid", {7'd0, out_transmit_valid}, {7'd0, want.tx_valid});
          if (out_buffer_byte !== want.rd_data)
            report_mismatch("buffer_byte", out_buffer_byte, want.rd_data);
          if (out_busy_res !== want.busy)
            report_mismatch("busy_res", {7'd0, out_busy_res}, {7'd0, want.busy});
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(sequencer_step(op_t'(in_operation), in_buffer_index,
                                                 in_data_byte, status_t'(in_bus_status)));
    end
    pending <= awaited_results.size();
  end

endmodule

// ----- tb/i2c_master_write_read_sequencer_core_tb.sv -----
// ----------------------------------------------------------------------------
// i2c_master_write_read_sequencer_core_tb
// Drives the sequencer with a short directed run and then with phases of
// random transactions, mostly well-formed write/read sequences with noise
// and broken sequences mixed in, under several register settings. Both
// channels idle at random; the checker beside the block judges every item.
// ----------------------------------------------------------------------------
module i2c_master_write_read_sequencer_core_tb;
  import i2cwr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_operation = '0;
  logic [3:0]           in_buffer_index = '0;
  logic [7:0]           in_data_byte = '0;
  logic [2:0]           in_bus_status = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_bus_command;
  logic [7:0]           out_transmit_byte;
  logic                 out_transmit_valid;
  logic [7:0]           out_buffer_byte;
  logic                 out_busy_res;

  int errors;
  int pending;
  int checked;
  int items_sent;
  int cycles;
  bit calm;
  bit hold_request;
  bit seq_broken;
  logic [CNT_W-1:0] cur_wcnt;
  logic [CNT_W-1:0] cur_rcnt;

  i2c_master_write_read_sequencer_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_buffer_index   (in_buffer_index),
    .in_data_byte      (in_data_byte),
    .in_bus_status     (in_bus_status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bus_command   (out_bus_command),
    .out_transmit_byte (out_transmit_byte),
    .out_transmit_valid(out_transmit_valid),
    .out_buffer_byte   (out_buffer_byte),
    .out_busy_res      (out_busy_res)
  );

  i2c_master_write_read_sequencer_core_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_buffer_index   (in_buffer_index),
    .in_data_byte      (in_data_byte),
    .in_bus_status     (in_bus_status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bus_command   (out_bus_command),
    .out_transmit_byte (out_transmit_byte),
    .out_transmit_valid(out_transmit_valid),
    .out_buffer_byte   (out_buffer_byte),
    .out_busy_res      (out_busy_res),
    .errors            (errors),
    .pending           (pending),
    .checked           (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL i2c_master_write_read_sequencer_core");
    $finish;
  end

  initial begin
    int hold_cycles;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cycles  = 0;
        out_stall <= 1'b1;
        while (hold_cycles < 80) begin
          @(posedge clk);
          hold_cycles++;
        end
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 26);
      end
    end
  end

  task automatic send_item(op_t op, logic [3:0] idx, logic [7:0] data, status_t st);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_buffer_index <= idx;
    in_data_byte    <= data;
    in_bus_status   <= st;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(op_t'($urandom_range(3)), 4'($urandom_range(15)), 8'($urandom_range(255)),
              status_t'($urandom_range(7)));
  endtask

  task automatic send_event(status_t st);
    if (seq_broken) return;
    if ($urandom_range(99) < 8) send_noise();
    if ($urandom_range(99) < 2) begin
      seq_broken = 1'b1;
      send_item(OP_EVENT, 4'($urandom_range(15)), 8'($urandom_range(255)),
                status_t'($urandom_range(7)));
    end else begin
      send_item(OP_EVENT, 4'($urandom_range(15)), 8'($urandom_range(255)), st);
    end
  endtask

  task automatic run_transaction();
    int extra;
    seq_broken = 1'b0;
    if ($urandom_range(99) < 30) send_noise();
    send_item(OP_BEGIN, 4'($urandom_range(15)), 8'($urandom_range(255)),
              status_t'($urandom_range(7)));
    send_event(ST_START);
    if (cur_wcnt != 0) begin
      send_event(ST_ADDR_W_OK);
      for (int i = 0; i < cur_wcnt; i++) send_event(ST_DATA_OK);
      if (cur_rcnt != 0) send_event(ST_RESTART);
    end
    if (cur_wcnt == 0 || cur_rcnt != 0) begin
      send_event(ST_ADDR_R_OK);
      extra = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : 0;
      for (int i = 1; i < int'(cur_rcnt) + extra; i++) send_event(ST_RX_ACK);
      send_event(ST_RX_NACK);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_config(logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] wcnt,
                            logic [CNT_W-1:0] rcnt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLAVE_ADDR;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_index <= CFG_WRITE_COUNT;
    cfg_data  <= CFG_DW'(wcnt);
    @(posedge clk);
    cfg_index <= CFG_READ_COUNT;
    cfg_data  <= CFG_DW'(rcnt);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_wcnt = wcnt;
    cur_rcnt = rcnt;
  endtask

  initial begin
    int target;
    cur_wcnt = '0;
    cur_rcnt = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < BUF_DEPTH; i++)
      send_item(OP_LOAD, 4'(i), (i == 0) ? 8'h00 : (i == BUF_DEPTH - 1) ? 8'hFF :
                8'($urandom_range(255)), ST_ERROR);
    send_item(OP_READ, 4'd0, 8'hFF, ST_START);
    send_item(OP_READ, 4'd15, 8'h00, ST_ERROR);
    send_item(OP_EVENT, 4'd0, 8'h00, ST_DATA_OK);
    send_item(OP_BEGIN, 4'd15, 8'hFF, ST_ERROR);
    send_item(OP_BEGIN, 4'd0, 8'h00, ST_START);
    send_item(OP_EVENT, 4'd0, 8'h00, ST_START);
    send_item(OP_EVENT, 4'd15, 8'hFF, ST_ERROR);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(7'h7F, 5'd16, 5'd16);
        1: set_config(7'h00, 5'd0, 5'd0);
        2: set_config(7'($urandom_range(127)), 5'd0, 5'd16);
        3: set_config(7'($urandom_range(127)), 5'd16, 5'd0);
        4: set_config(7'($urandom_range(127)), 5'd1, 5'd1);
        default: set_config(7'($urandom_range(127)), 5'($urandom_range(16)),
                            5'($urandom_range(16)));
      endcase
      calm = (ph == 3);
      if (ph == 1 || ph == 5) hold_request = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_transaction();
      drain();
    end
    calm = 1'b0;

    repeat (6) @(posedge clk);
    $display("Run covered %0d input items under %0d register settings, %0d results checked",
             items_sent, PHASES + 1, checked);
    if (errors == 0) begin
      $display("PASS i2c_master_write_read_sequencer_core");
    end else begin
      $display("FAIL i2c_master_write_read_sequencer_core");
    end
    $finish;
  end

endmodule

// ----- i2c_master_write_read_sequencer_core.f -----
sv/i2cwr_pkg.sv
sv/i2c_master_write_read_sequencer_core.sv
tb/i2c_master_write_read_sequencer_core_checker.sv
tb/i2c_master_write_read_sequencer_core_tb.sv
